// ----- hw/rtl/scot_pkg.sv -----
// Shared widths for the sphere-capsule overlap test pipeline.
// Used by scot_wide_mul and sphere_capsule_overlap_test_core; no dependencies.
`timescale 1ns / 1ps

package scot_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int RAD_WIDTH   = COORD_WIDTH - 1;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 2;
    localparam int HALF_WIDTH  = SUM_WIDTH / 2;
    localparam int WIDE_WIDTH  = 2 * SUM_WIDTH;
    localparam int RSUM_WIDTH  = COORD_WIDTH;
    localparam int RSQ_WIDTH   = 2 * RSUM_WIDTH;
endpackage

// ----- hw/rtl/scot_wide_mul.sv -----
// Two-stage unsigned multiplier built from four half-width partial products.
// Depends on scot_pkg for operand and product widths.
`timescale 1ns / 1ps

module scot_wide_mul (
    input  logic                                clk,
    input  logic                                en,
    input  logic [scot_pkg::SUM_WIDTH-1:0]      a,
    input  logic [scot_pkg::SUM_WIDTH-1:0]      b,
    output logic [scot_pkg::WIDE_WIDTH-1:0]     product
);
    localparam int HW = scot_pkg::HALF_WIDTH;
    localparam int SW = scot_pkg::SUM_WIDTH;
    localparam int MW = scot_pkg::WIDE_WIDTH;

    logic [2*HW-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [MW-1:0]   product_reg;
    logic [MW-1:0]   product_next;

    always_comb
    begin
        product_next = MW'(pp_ll_reg)
                     + (MW'(pp_lh_reg) << HW)
                     + (MW'(pp_hl_reg) << HW)
                     + (MW'(pp_hh_reg) << (2 * HW));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg   <= (2*HW)'(a[HW-1:0])  * (2*HW)'(b[HW-1:0]);
            pp_lh_reg   <= (2*HW)'(a[HW-1:0])  * (2*HW)'(b[SW-1:HW]);
            pp_hl_reg   <= (2*HW)'(a[SW-1:HW]) * (2*HW)'(b[HW-1:0]);
            pp_hh_reg   <= (2*HW)'(a[SW-1:HW]) * (2*HW)'(b[SW-1:HW]);
            product_reg <= product_next;
        end
    end

    assign product = product_reg;
endmodule

// ----- hw/rtl/sphere_capsule_overlap_test_core.sv -----
// Sphere-capsule overlap test: seven-stage pipeline, one request per cycle unless stalled.
// Throughput is one request per cycle when the output is not stalled, set by the fully
// pipelined multipliers. A stalled output holds every stage in place. Reset clears only
// the stage valid bits.
// Depends on scot_pkg and scot_wide_mul.
`timescale 1ns / 1ps

module sphere_capsule_overlap_test_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [scot_pkg::COORD_WIDTH-1:0] sphere_cx,
    input  logic signed [scot_pkg::COORD_WIDTH-1:0] sphere_cy,
    input  logic signed [scot_pkg::COORD_WIDTH-1:0] sphere_cz,
    input  logic [scot_pkg::RAD_WIDTH-1:0]      sphere_rad,
    input  logic signed [scot_pkg::COORD_WIDTH-1:0] seg_start_x,
    input  logic signed [scot_pkg::COORD_WIDTH-1:0] seg_start_y,
    input  logic signed [scot_pkg::COORD_WIDTH-1:0] seg_start_z,
    input  logic signed [scot_pkg::COORD_WIDTH-1:0] seg_end_x,
    input  logic signed [scot_pkg::COORD_WIDTH-1:0] seg_end_y,
    input  logic signed [scot_pkg::COORD_WIDTH-1:0] seg_end_z,
    input  logic [scot_pkg::RAD_WIDTH-1:0]      capsule_rad,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit
);
    localparam int DW = scot_pkg::DIFF_WIDTH;
    localparam int PW = scot_pkg::PROD_WIDTH;
    localparam int SW = scot_pkg::SUM_WIDTH;
    localparam int MW = scot_pkg::WIDE_WIDTH;
    localparam int RW = scot_pkg::RSUM_WIDTH;
    localparam int QW = scot_pkg::RSQ_WIDTH;

    logic adv;
    logic [6:0] valid_reg;

    assign adv       = out_ready || !valid_reg[6];
    assign in_ready  = adv;
    assign out_valid = valid_reg[6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    // Stage 1: coordinate differences and radius sum.
    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] b_reg [3];
    logic signed [DW-1:0] q_reg [3];
    logic [RW-1:0]        rsum_reg;
    logic signed [scot_pkg::COORD_WIDTH-1:0] cc [3];
    logic signed [scot_pkg::COORD_WIDTH-1:0] aa [3];
    logic signed [scot_pkg::COORD_WIDTH-1:0] ee [3];

    assign cc = '{sphere_cx, sphere_cy, sphere_cz};
    assign aa = '{seg_start_x, seg_start_y, seg_start_z};
    assign ee = '{seg_end_x, seg_end_y, seg_end_z};

    // Stage 2: products.
    logic signed [PW-1:0] dd_reg [3];
    logic signed [PW-1:0] qq_reg [3];
    logic signed [PW-1:0] bb_reg [3];
    logic signed [PW-1:0] db_reg [3];
    logic [QW-1:0]        r2_s2_reg;

    // Stage 3: sums.
    logic [SW-1:0]        dd2_reg, qq2_reg, len2_reg;
    logic signed [SW-1:0] dot_reg;
    logic [QW-1:0]        r2_s3_reg;

    // Stage 4: end-case flags; stage 5 carries them while the products finish.
    logic t0_s4_reg, t1_s4_reg, h0_s4_reg, h1_s4_reg;
    logic t0_s5_reg, t1_s5_reg, h0_s5_reg, h1_s5_reg;
    logic t0_s6_reg, t1_s6_reg, h0_s6_reg, h1_s6_reg;
    logic [MW-1:0] lhs_prod, dot_prod, rl_prod;
    logic [MW-1:0] lhs_reg, rhs_reg;
    logic          hit_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_reg[k]  <= DW'(cc[k]) - DW'(aa[k]);
                b_reg[k]  <= DW'(ee[k]) - DW'(aa[k]);
                q_reg[k]  <= DW'(cc[k]) - DW'(ee[k]);
                dd_reg[k] <= PW'(d_reg[k]) * PW'(d_reg[k]);
                qq_reg[k] <= PW'(q_reg[k]) * PW'(q_reg[k]);
                bb_reg[k] <= PW'(b_reg[k]) * PW'(b_reg[k]);
                db_reg[k] <= PW'(d_reg[k]) * PW'(b_reg[k]);
            end
            rsum_reg  <= RW'(sphere_rad) + RW'(capsule_rad);
            r2_s2_reg <= QW'(rsum_reg) * QW'(rsum_reg);

            dd2_reg   <= SW'(dd_reg[0]) + SW'(dd_reg[1]) + SW'(dd_reg[2]);
            qq2_reg   <= SW'(qq_reg[0]) + SW'(qq_reg[1]) + SW'(qq_reg[2]);
            len2_reg  <= SW'(bb_reg[0]) + SW'(bb_reg[1]) + SW'(bb_reg[2]);
            dot_reg   <= SW'(db_reg[0]) + SW'(db_reg[1]) + SW'(db_reg[2]);
            r2_s3_reg <= r2_s2_reg;

            t0_s4_reg <= (dot_reg <= 0);
            t1_s4_reg <= (dot_reg > 0) && (SW'(dot_reg) >= len2_reg);
            h0_s4_reg <= dd2_reg < SW'(r2_s3_reg);
            h1_s4_reg <= qq2_reg < SW'(r2_s3_reg);

            t0_s5_reg <= t0_s4_reg;
            t1_s5_reg <= t1_s4_reg;
            h0_s5_reg <= h0_s4_reg;
            h1_s5_reg <= h1_s4_reg;

            lhs_reg   <= lhs_prod;
            rhs_reg   <= dot_prod + rl_prod;
            t0_s6_reg <= t0_s5_reg;
            t1_s6_reg <= t1_s5_reg;
            h0_s6_reg <= h0_s5_reg;
            h1_s6_reg <= h1_s5_reg;

            if (t0_s6_reg)
            begin
                hit_reg <= h0_s6_reg;
            end
            else if (t1_s6_reg)
            begin
                hit_reg <= h1_s6_reg;
            end
            else
            begin
                hit_reg <= lhs_reg < rhs_reg;
            end
        end
    end

    scot_wide_mul u_mul_lhs (
        .clk     (clk),
        .en      (adv),
        .a       (dd2_reg),
        .b       (len2_reg),
        .product (lhs_prod)
    );

    scot_wide_mul u_mul_dot (
        .clk     (clk),
        .en      (adv),
        .a       (SW'(dot_reg)),
        .b       (SW'(dot_reg)),
        .product (dot_prod)
    );

    scot_wide_mul u_mul_rl (
        .clk     (clk),
        .en      (adv),
        .a       (SW'(r2_s3_reg)),
        .b       (len2_reg),
        .product (rl_prod)
    );

    assign hit = hit_reg;
endmodule

// ----- bench/sphere_capsule_overlap_test_core_tb.sv -----
// Self-checking testbench for sphere_capsule_overlap_test_core: directed and random requests,
// each checked against an exact wide-integer overlap predictor.
// Depends on scot_pkg and the core RTL.
`timescale 1ns / 1ps

module sphere_capsule_overlap_test_core_tb;
    localparam int RW = scot_pkg::RAD_WIDTH;

    typedef struct packed {
        logic [2:0][scot_pkg::COORD_WIDTH-1:0] ctr;
        logic [2:0][scot_pkg::COORD_WIDTH-1:0] sa;
        logic [2:0][scot_pkg::COORD_WIDTH-1:0] se;
        logic [scot_pkg::RAD_WIDTH-1:0]        sr;
        logic [scot_pkg::RAD_WIDTH-1:0]        cr;
    } pair_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [scot_pkg::COORD_WIDTH-1:0] sphere_cx, sphere_cy, sphere_cz;
    logic [scot_pkg::RAD_WIDTH-1:0] sphere_rad;
    logic signed [scot_pkg::COORD_WIDTH-1:0] seg_start_x, seg_start_y, seg_start_z;
    logic signed [scot_pkg::COORD_WIDTH-1:0] seg_end_x, seg_end_y, seg_end_z;
    logic [scot_pkg::RAD_WIDTH-1:0] capsule_rad;
    logic out_valid;
    logic out_ready;
    logic hit;

    bit   hit_q[$];
    int   fail_count;
    int   hold_off_req;
    int   rx_cycle;
    int   hold_left;

    sphere_capsule_overlap_test_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .sphere_cx(sphere_cx), .sphere_cy(sphere_cy), .sphere_cz(sphere_cz),
        .sphere_rad(sphere_rad),
        .seg_start_x(seg_start_x), .seg_start_y(seg_start_y), .seg_start_z(seg_start_z),
        .seg_end_x(seg_end_x), .seg_end_y(seg_end_y), .seg_end_z(seg_end_z),
        .capsule_rad(capsule_rad),
        .out_valid(out_valid), .out_ready(out_ready), .hit(hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit overlap_hit(pair_t p);
        logic signed [33:0]  d, b, q;
        logic signed [71:0]  dot, dd2, qq2, len2;
        logic [63:0]         rsq;
        logic [159:0]        lhs, rhs, udot, ulen;
        int k;
        dot = '0; dd2 = '0; qq2 = '0; len2 = '0;
        for (k = 0; k < 3; k++)
        begin
            d = $signed(p.ctr[k]) - $signed(p.sa[k]);
            b = $signed(p.se[k]) - $signed(p.sa[k]);
            q = $signed(p.ctr[k]) - $signed(p.se[k]);
            dot  = dot + d * b;
            dd2  = dd2 + d * d;
            qq2  = qq2 + q * q;
            len2 = len2 + b * b;
        end
        rsq = {32'b0, {1'b0, p.sr} + {1'b0, p.cr}};
        rsq = rsq * rsq;
        if (dot <= 0)
            return $unsigned(dd2) < {8'b0, rsq};
        if (dot >= len2)
            return $unsigned(qq2) < {8'b0, rsq};
        udot = {88'b0, $unsigned(dot)};
        ulen = {88'b0, $unsigned(len2)};
        lhs  = {88'b0, $unsigned(dd2)} * ulen;
        rhs  = udot * udot + {96'b0, rsq} * ulen;
        return lhs < rhs;
    endfunction

    task automatic send_pair(pair_t p);
        in_valid    <= 1'b1;
        sphere_cx   <= p.ctr[0];
        sphere_cy   <= p.ctr[1];
        sphere_cz   <= p.ctr[2];
        seg_start_x <= p.sa[0];
        seg_start_y <= p.sa[1];
        seg_start_z <= p.sa[2];
        seg_end_x   <= p.se[0];
        seg_end_y   <= p.se[1];
        seg_end_z   <= p.se[2];
        sphere_rad  <= p.sr;
        capsule_rad <= p.cr;
        do
            @(posedge clk);
        while (!in_ready);
        hit_q.push_back(overlap_hit(p));
    endtask

    task automatic idle_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (hit_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic pair_t make_pair(int cx, int cy, int cz, int ax, int ay, int az,
                                        int ex, int ey, int ez, int r1, int r2);
        pair_t p;
        p.ctr[0] = cx; p.ctr[1] = cy; p.ctr[2] = cz;
        p.sa[0]  = ax; p.sa[1]  = ay; p.sa[2]  = az;
        p.se[0]  = ex; p.se[1]  = ey; p.se[2]  = ez;
        p.sr = r1[RW-1:0];
        p.cr = r2[RW-1:0];
        return p;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int mode;
        int k;
        mode = $urandom_range(0, 9);
        for (k = 0; k < 3; k++)
        begin
            if (mode < 2)
            begin
                p.ctr[k] = $urandom; p.sa[k] = $urandom; p.se[k] = $urandom;
            end
            else if (mode < 8)
            begin
                p.ctr[k] = $urandom_range(0, 16) - 8;
                p.sa[k]  = $urandom_range(0, 16) - 8;
                p.se[k]  = (mode == 7) ? p.sa[k] : $urandom_range(0, 16) - 8;
            end
            else
            begin
                p.ctr[k] = ($urandom_range(0, 2000) - 1000) <<< 16;
                p.sa[k]  = ($urandom_range(0, 2000) - 1000) <<< 16;
                p.se[k]  = ($urandom_range(0, 2000) - 1000) <<< 16;
            end
        end
        if (mode < 2)
        begin
            p.sr = RW'($urandom); p.cr = RW'($urandom);
        end
        else if (mode < 8)
        begin
            p.sr = RW'($urandom_range(0, 8)); p.cr = RW'($urandom_range(0, 8));
        end
        else
        begin
            p.sr = RW'($urandom_range(0, 600) << 16);
            p.cr = RW'($urandom_range(0, 600) << 16);
        end
        return p;
    endfunction

    task automatic test_field_extremes();
        int mx;
        int mn;
        int rmax;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        rmax = 32'h7fffffff;
        send_pair(make_pair(mx, mx, mx, mx, mx, mx, mx, mx, mx, rmax, rmax));
        send_pair(make_pair(mn, mn, mn, mn, mn, mn, mn, mn, mn, 0, 0));
        send_pair(make_pair(mx, mx, mx, mn, mn, mn, mx, mx, mx, 0, 0));
        send_pair(make_pair(mn, mx, mn, mx, mn, mx, mn, mn, mn, rmax, rmax));
        send_pair(make_pair(mx, mn, mx, mn, mx, mn, mn, mx, mn, rmax, 0));
        send_pair(make_pair(-1, -1, -1, 0, 0, 0, mx, mn, mx, 0, rmax));
        send_pair(make_pair(0, 0, 0, mn, mn, mn, mx, mx, mx, 1, 0));
        idle_sender(3);
    endtask

    task automatic test_special_cases();
        // Zero-length segment: the capsule degenerates to a sphere at its start.
        send_pair(make_pair(5, 0, 0, 0, 0, 0, 0, 0, 0, 2, 3));
        send_pair(make_pair(5, 0, 0, 0, 0, 0, 0, 0, 0, 3, 3));
        // Projection falls before the segment start.
        send_pair(make_pair(-6, 0, 0, 0, 0, 0, 10, 0, 0, 3, 3));
        send_pair(make_pair(-6, 0, 0, 0, 0, 0, 10, 0, 0, 3, 4));
        // Projection falls past the segment end.
        send_pair(make_pair(16, 0, 0, 0, 0, 0, 10, 0, 0, 3, 3));
        send_pair(make_pair(16, 0, 0, 0, 0, 0, 10, 0, 0, 4, 3));
        // Interior projection, touching exactly and just overlapping.
        send_pair(make_pair(4, 0, 0, 0, -10, 0, 0, 10, 0, 2, 2));
        send_pair(make_pair(4, 0, 0, 0, -10, 0, 0, 10, 0, 2, 3));
        send_pair(make_pair(3, 4, 0, 0, 0, -7, 0, 0, 7, 1, 4));
        send_pair(make_pair(3, 4, 0, 0, 0, -7, 0, 0, 7, 1, 5));
        // Projection exactly on an endpoint.
        send_pair(make_pair(0, 3, 0, 0, 0, 0, 10, 0, 0, 1, 1));
        send_pair(make_pair(10, 3, 0, 0, 0, 0, 10, 0, 0, 2, 2));
        wait_drained();
    endtask

    task automatic test_random_traffic(int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < n)
            begin
                send_pair(random_pair());
                sent++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
        end
    endtask

    task automatic test_backpressure();
        int k;
        hold_off_req = 1;
        for (k = 0; k < 40; k++)
            send_pair(random_pair());
        wait_drained();
    endtask

    initial
    begin
        in_valid = 1'b0;
        {sphere_cx, sphere_cy, sphere_cz, sphere_rad} = '0;
        {seg_start_x, seg_start_y, seg_start_z} = '0;
        {seg_end_x, seg_end_y, seg_end_z, capsule_rad} = '0;
        fail_count = 0;
        hold_off_req = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_special_cases();
        test_random_traffic(200);
        test_backpressure();
        test_random_traffic(200);
        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && hit_q.size() == 0)
            $display("sphere_capsule_overlap_test_core regression: pass");
        else
            $display("sphere_capsule_overlap_test_core regression: fail");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        rx_cycle = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (hold_off_req != 0)
            begin
                hold_off_req = 0;
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if ((rx_cycle / 50) % 3 == 0)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (hit_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual hit=%0b", $time, hit);
                fail_count++;
            end
            else
            begin
                if (hit !== hit_q[0])
                begin
                    $display("%0t: hit mismatch, expected %0b, actual %0b",
                             $time, hit_q[0], hit);
                    fail_count++;
                end
                void'(hit_q.pop_front());
            end
        end
    end

    initial
    begin
        #2000000;
        $display("sphere_capsule_overlap_test_core regression: fail");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/scot_pkg.sv
hw/rtl/scot_wide_mul.sv
hw/rtl/sphere_capsule_overlap_test_core.sv
bench/sphere_capsule_overlap_test_core_tb.sv
